### rtl/core/loc_pkg.sv
// Package of shared types and constants for the LRU object cache directory.
package loc_pkg;

    localparam int SLOTS = 16;
    localparam int KEY_BITS = 32;
    localparam int STAMP_BITS = 32;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOTAL_W = 26;

    localparam logic [23:0] BUDGET_RESET = 24'd1049000;
    localparam logic [19:0] LIMIT_RESET = 20'd102400;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        STS_HIT = 3'd0,
        STS_MISS = 3'd1,
        STS_NEW = 3'd2,
        STS_OVERWRITE = 3'd3,
        STS_REJECT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FIT,
        S_DROP
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [19:0] obj_size;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slot;
        logic [19:0] hit_size;
        logic [4:0]  evictions;
        logic [23:0] bytes_used;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [19:0]           size;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

endpackage

### rtl/core/loc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module loc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lru_object_cache_directory_core.sv
// Top level of the LRU object cache directory with a byte budget.
// Every command except a rejected store scans all slot entries in the directory RAM, one read per
// cycle. A lookup gives its result beat after its scan and the decide state, and a rejected store
// gives it in the next cycle. A store that evicts nothing gives it after the scan, decide and fit
// states; each evicted slot, including the one replaced in a full directory, adds a further scan
// and the drop and fit states. The result beat appears on rsp for exactly one
// cycle with done high and cannot be held off; busy is low again from the cycle of that beat.
module lru_object_cache_directory_core
    import loc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [23:0] cfg_data
);

    state_t state_reg, state_next;
    logic cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [19:0] size_reg, size_next;
    logic [SLOT_W:0] rd_cnt_reg, rd_cnt_next;
    logic dv_reg, dv_next;
    logic [SLOT_W-1:0] di_reg, di_next;
    logic found_reg, found_next;
    logic [SLOT_W-1:0] match_reg, match_next;
    logic [19:0] msize_reg, msize_next;
    logic lru_found_reg, lru_found_next;
    logic [SLOT_W-1:0] lru_reg, lru_next;
    logic [STAMP_BITS-1:0] lru_stamp_reg, lru_stamp_next;
    logic [19:0] lru_size_reg, lru_size_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [STAMP_BITS-1:0] clock_reg, clock_next;
    logic ow_reg, ow_next;
    logic evict_reg, evict_next;
    logic [4:0] ev_reg, ev_next;
    logic [23:0] budget_reg, budget_next;
    logic [19:0] limit_reg, limit_next;
    rsp_t rsp_reg, rsp_next;
    logic done_reg, done_next;

    logic ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    entry_t ram_wdata;
    entry_t ram_rdata;

    logic accept;
    logic scan_last;
    logic over_budget;
    logic [19:0] need;
    logic [SLOT_W-1:0] free_idx;
    logic [STAMP_BITS-1:0] stamp_inc;

    loc_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_cnt_reg[SLOT_W-1:0]),
        .rdata(ram_rdata)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp = rsp_reg;
    assign scan_last = dv_reg && (di_reg == SLOT_W'(SLOTS - 1));
    assign need = ow_reg ? 20'd0 : size_reg;
    assign over_budget = (total_reg + TOTAL_W'(need)) > TOTAL_W'(budget_reg);
    assign stamp_inc = clock_reg + STAMP_BITS'(1);

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !(req.cmd == CMD_STORE && req.obj_size > limit_reg))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = evict_reg ? S_DROP : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = (cmd_reg == CMD_LOOKUP) ? S_IDLE : S_FIT;
            end
            S_FIT:
            begin
                if ((over_budget && (|valid_reg)) || (!ow_reg && (&valid_reg)))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DROP:
            begin
                state_next = S_FIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        key_next = key_reg;
        size_next = size_reg;
        rd_cnt_next = rd_cnt_reg;
        dv_next = 1'b0;
        di_next = di_reg;
        found_next = found_reg;
        match_next = match_reg;
        msize_next = msize_reg;
        lru_found_next = lru_found_reg;
        lru_next = lru_reg;
        lru_stamp_next = lru_stamp_reg;
        lru_size_next = lru_size_reg;
        valid_next = valid_reg;
        total_next = total_reg;
        clock_next = clock_reg;
        ow_next = ow_reg;
        evict_next = evict_reg;
        ev_next = ev_reg;
        budget_next = budget_reg;
        limit_next = limit_reg;
        rsp_next = rsp_reg;
        done_next = 1'b0;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;

        if (cfg_we)
        begin
            if (cfg_idx == CFG_BUDGET)
            begin
                budget_next = cfg_data;
            end
            else
            begin
                limit_next = cfg_data[19:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    key_next = req.key[KEY_BITS-1:0];
                    size_next = req.obj_size;
                    rd_cnt_next = '0;
                    found_next = 1'b0;
                    lru_found_next = 1'b0;
                    ow_next = 1'b0;
                    evict_next = 1'b0;
                    ev_next = '0;
                    if (req.cmd == CMD_STORE && req.obj_size > limit_reg)
                    begin
                        rsp_next.status = STS_REJECT;
                        rsp_next.slot = '0;
                        rsp_next.hit_size = '0;
                        rsp_next.evictions = '0;
                        rsp_next.bytes_used = total_reg[23:0];
                        done_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_cnt_reg < (SLOT_W + 1)'(SLOTS))
                begin
                    rd_cnt_next = rd_cnt_reg + (SLOT_W + 1)'(1);
                    dv_next = 1'b1;
                    di_next = rd_cnt_reg[SLOT_W-1:0];
                end
                if (dv_reg && valid_reg[di_reg])
                begin
                    if (!found_reg && ram_rdata.key == key_reg)
                    begin
                        found_next = 1'b1;
                        match_next = di_reg;
                        msize_next = ram_rdata.size;
                    end
                    if (!lru_found_reg || ram_rdata.stamp < lru_stamp_reg)
                    begin
                        lru_found_next = 1'b1;
                        lru_next = di_reg;
                        lru_stamp_next = ram_rdata.stamp;
                        lru_size_next = ram_rdata.size;
                    end
                end
            end
            S_DECIDE:
            begin
                rsp_next.evictions = '0;
                rsp_next.hit_size = '0;
                rsp_next.slot = '0;
                rsp_next.bytes_used = total_reg[23:0];
                if (cmd_reg == CMD_LOOKUP)
                begin
                    done_next = 1'b1;
                    if (found_reg)
                    begin
                        clock_next = stamp_inc;
                        ram_we = 1'b1;
                        ram_waddr = match_reg;
                        ram_wdata.key = key_reg;
                        ram_wdata.size = msize_reg;
                        ram_wdata.stamp = stamp_inc;
                        rsp_next.status = STS_HIT;
                        rsp_next.slot = 4'(match_reg);
                        rsp_next.hit_size = msize_reg;
                    end
                    else
                    begin
                        rsp_next.status = STS_MISS;
                    end
                end
                else if (found_reg)
                begin
                    clock_next = stamp_inc;
                    ram_we = 1'b1;
                    ram_waddr = match_reg;
                    ram_wdata.key = key_reg;
                    ram_wdata.size = size_reg;
                    ram_wdata.stamp = stamp_inc;
                    total_next = total_reg - TOTAL_W'(msize_reg) + TOTAL_W'(size_reg);
                    ow_next = 1'b1;
                end
            end
            S_FIT:
            begin
                rd_cnt_next = '0;
                lru_found_next = 1'b0;
                found_next = 1'b1;
                if ((over_budget && (|valid_reg)) || (!ow_reg && (&valid_reg)))
                begin
                    evict_next = 1'b1;
                end
                else if (ow_reg)
                begin
                    rsp_next.status = STS_OVERWRITE;
                    rsp_next.slot = 4'(match_reg);
                    rsp_next.hit_size = '0;
                    rsp_next.evictions = ev_reg;
                    rsp_next.bytes_used = total_reg[23:0];
                    done_next = 1'b1;
                end
                else
                begin
                    clock_next = stamp_inc;
                    ram_we = 1'b1;
                    ram_waddr = free_idx;
                    ram_wdata.key = key_reg;
                    ram_wdata.size = size_reg;
                    ram_wdata.stamp = stamp_inc;
                    valid_next[free_idx] = 1'b1;
                    total_next = total_reg + TOTAL_W'(size_reg);
                    rsp_next.status = STS_NEW;
                    rsp_next.slot = 4'(free_idx);
                    rsp_next.hit_size = '0;
                    rsp_next.evictions = ev_reg;
                    rsp_next.bytes_used = 24'(total_reg + TOTAL_W'(size_reg));
                    done_next = 1'b1;
                end
            end
            S_DROP:
            begin
                valid_next[lru_reg] = 1'b0;
                total_next = total_reg - TOTAL_W'(lru_size_reg);
                ev_next = ev_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            total_reg <= '0;
            clock_reg <= '0;
            budget_reg <= BUDGET_RESET;
            limit_reg <= LIMIT_RESET;
            done_reg <= 1'b0;
            dv_reg <= 1'b0;
            rd_cnt_reg <= '0;
            found_reg <= 1'b0;
            lru_found_reg <= 1'b0;
            ow_reg <= 1'b0;
            evict_reg <= 1'b0;
            ev_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            total_reg <= total_next;
            clock_reg <= clock_next;
            budget_reg <= budget_next;
            limit_reg <= limit_next;
            done_reg <= done_next;
            dv_reg <= dv_next;
            rd_cnt_reg <= rd_cnt_next;
            found_reg <= found_next;
            lru_found_reg <= lru_found_next;
            ow_reg <= ow_next;
            evict_reg <= evict_next;
            ev_reg <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        size_reg <= size_next;
        di_reg <= di_next;
        match_reg <= match_next;
        msize_reg <= msize_next;
        lru_reg <= lru_next;
        lru_stamp_reg <= lru_stamp_next;
        lru_size_reg <= lru_size_next;
        rsp_reg <= rsp_next;
    end

endmodule

### dv/tb_lru_object_cache_directory_core.sv
// Testbench for the LRU object cache directory: directed and random commands with a predictor.
module tb_lru_object_cache_directory_core;
    import loc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic        cfg_idx;
    logic [23:0] cfg_data;

    lru_object_cache_directory_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    logic [23:0] dir_budget;
    logic [19:0] dir_limit;
    logic        dir_valid [SLOTS];
    logic [31:0] dir_key [SLOTS];
    logic [19:0] dir_size [SLOTS];
    logic [31:0] dir_stamp [SLOTS];
    logic [25:0] dir_total;
    logic [31:0] dir_clock;

    rsp_t pending_rsp [$];
    int   errors;
    int   beats_sent;
    int   beats_checked;
    int   stores_seen;
    int   evict_seen;
    bit   quiet;

    logic [31:0] key_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int lru_slot();
        int v;
        v = -1;
        for (int i = 0; i < SLOTS; i++)
            if (dir_valid[i] && (v < 0 || dir_stamp[i] < dir_stamp[v]))
                v = i;
        return v;
    endfunction

    function automatic void drop_entry(int i);
        dir_total -= dir_size[i];
        dir_valid[i] = 1'b0;
        dir_key[i] = '0;
        dir_size[i] = '0;
        dir_stamp[i] = '0;
    endfunction

    function automatic int shed_to_fit(logic [25:0] need);
        int n;
        int v;
        n = 0;
        while (dir_total + need > {2'b00, dir_budget})
        begin
            v = lru_slot();
            if (v < 0)
                break;
            drop_entry(v);
            n++;
        end
        return n;
    endfunction

    function automatic rsp_t predict_directory(req_t r);
        rsp_t o;
        int   hit;
        int   ev;
        hit = -1;
        ev = 0;
        o = '0;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && dir_valid[i] && dir_key[i] == r.key)
                hit = i;
        if (r.cmd == CMD_LOOKUP)
        begin
            if (hit >= 0)
            begin
                dir_clock++;
                dir_stamp[hit] = dir_clock;
                o.status = STS_HIT;
                o.slot = hit[3:0];
                o.hit_size = dir_size[hit];
            end
            else
                o.status = STS_MISS;
        end
        else if (r.obj_size > dir_limit)
            o.status = STS_REJECT;
        else if (hit >= 0)
        begin
            dir_total -= dir_size[hit];
            dir_size[hit] = r.obj_size;
            dir_clock++;
            dir_stamp[hit] = dir_clock;
            dir_total += r.obj_size;
            ev = shed_to_fit('0);
            o.status = STS_OVERWRITE;
            o.slot = hit[3:0];
        end
        else
        begin
            ev = shed_to_fit({6'd0, r.obj_size});
            for (int j = 0; j < SLOTS; j++)
                if (hit < 0 && !dir_valid[j])
                    hit = j;
            if (hit < 0)
            begin
                hit = lru_slot();
                if (hit < 0)
                    hit = 0;
                drop_entry(hit);
                ev++;
            end
            dir_valid[hit] = 1'b1;
            dir_key[hit] = r.key;
            dir_size[hit] = r.obj_size;
            dir_clock++;
            dir_stamp[hit] = dir_clock;
            dir_total += r.obj_size;
            o.status = STS_NEW;
            o.slot = hit[3:0];
        end
        o.evictions = ev[4:0];
        o.bytes_used = dir_total[23:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            beats_checked++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, rsp);
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
                    errors++;
                end
                if (rsp.slot !== e.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, e.slot, rsp.slot);
                    errors++;
                end
                if (rsp.hit_size !== e.hit_size)
                begin
                    $display("%0t: hit_size expected %0d actual %0d", $time, e.hit_size,
                             rsp.hit_size);
                    errors++;
                end
                if (rsp.evictions !== e.evictions)
                begin
                    $display("%0t: evictions expected %0d actual %0d", $time, e.evictions,
                             rsp.evictions);
                    errors++;
                end
                if (rsp.bytes_used !== e.bytes_used)
                begin
                    $display("%0t: bytes_used expected %0d actual %0d", $time, e.bytes_used,
                             rsp.bytes_used);
                    errors++;
                end
                if (e.status == STS_NEW || e.status == STS_OVERWRITE)
                    stores_seen++;
                evict_seen += e.evictions;
            end
        end
    end

    task automatic send_beat(logic c, logic [31:0] k, logic [19:0] s);
        req_t r;
        if (!quiet)
            while ($urandom_range(99) < 36)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        r.cmd = c;
        r.key = k;
        r.obj_size = s;
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(predict_directory(r));
        beats_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BUDGET)
            dir_budget = val;
        else
            dir_limit = val[19:0];
    endtask

    task automatic test_directed();
        send_beat(CMD_LOOKUP, 32'h0, 20'h0);
        send_beat(CMD_STORE, 32'h0, 20'h0);
        send_beat(CMD_LOOKUP, 32'h0, 20'hFFFFF);
        send_beat(CMD_STORE, 32'hFFFFFFFF, 20'd102400);
        send_beat(CMD_STORE, 32'h12345678, 20'd102401);
        send_beat(CMD_STORE, 32'hFFFFFFFF, 20'd500);
        send_beat(CMD_LOOKUP, 32'hFFFFFFFF, 20'd0);
        for (int i = 0; i < 16; i++)
            send_beat(CMD_STORE, 32'h100 + i, 20'd70000);
        send_beat(CMD_LOOKUP, 32'h0, 20'd0);
    endtask

    task automatic test_budget_extremes();
        write_reg(CFG_LIMIT, 24'hFFFFF);
        write_reg(CFG_BUDGET, 24'd0);
        send_beat(CMD_STORE, 32'hA5A5A5A5, 20'hFFFFF);
        send_beat(CMD_STORE, 32'h5A5A5A5A, 20'd0);
        send_beat(CMD_STORE, 32'hA5A5A5A5, 20'd10);
        write_reg(CFG_BUDGET, 24'hFFFFFF);
        for (int i = 0; i < 18; i++)
            send_beat(CMD_STORE, 32'h200 + i, 20'hFFFFF);
        write_reg(CFG_BUDGET, 24'd3000);
        send_beat(CMD_STORE, 32'h200, 20'd2000);
        send_beat(CMD_STORE, 32'h200, 20'd3500);
        write_reg(CFG_LIMIT, 24'd0);
        send_beat(CMD_STORE, 32'h300, 20'd1);
        send_beat(CMD_STORE, 32'h300, 20'd0);
    endtask

    task automatic test_random(int count);
        logic        c;
        logic [31:0] k;
        logic [19:0] s;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
            begin
                write_reg(CFG_BUDGET, 24'($urandom_range(1000, 200000)));
                write_reg(CFG_LIMIT, 24'($urandom_range(500, 60000)));
            end
            quiet = (i >= 300 && i < 400);
            c = 1'($urandom_range(1));
            if ($urandom_range(9) < 8)
                k = key_pool[$urandom_range(7)] ^ 32'($urandom_range(3));
            else
                k = $urandom;
            case ($urandom_range(4))
                0: s = 20'($urandom);
                1: s = 20'($urandom_range(0, 3));
                default: s = 20'($urandom_range(0, 40000));
            endcase
            send_beat(c, k, s);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        stores_seen = 0;
        evict_seen = 0;
        quiet = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_BUDGET;
        cfg_data = '0;
        dir_budget = BUDGET_RESET;
        dir_limit = LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_key[i] = '0;
            dir_size[i] = '0;
            dir_stamp[i] = '0;
        end
        dir_total = '0;
        dir_clock = '0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFFFFFC;
        for (int i = 2; i < 8; i++)
            key_pool[i] = $urandom;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_budget_extremes();
        test_random(800);
        wait_drained();
        $display("Covered %0d commands and %0d result beats, %0d stores, %0d evictions.",
                 beats_sent, beats_checked, stores_seen, evict_seen);
        $display("Budget and object limit were swept from zero to full scale.");
        if (errors == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/core/loc_pkg.sv
rtl/core/loc_ram.sv
rtl/core/lru_object_cache_directory_core.sv
dv/tb_lru_object_cache_directory_core.sv
